// ===== design/adaptive_prefix_traffic_counter_macros.svh =====
// Assertion macros for the prefix traffic counter.
`ifndef ADAPTIVE_PREFIX_TRAFFIC_COUNTER_MACROS_SVH
`define ADAPTIVE_PREFIX_TRAFFIC_COUNTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define APT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`else
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define APT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// ===== design/apt_pkg.sv =====
`default_nettype none
package apt_pkg;
    localparam int TABLES     = 64;
    localparam int LEVELS     = 4;
    localparam int PORTS      = 4;
    localparam int TABLE_W    = $clog2(TABLES);
    localparam int OCTET_BITS = 8;
    localparam int TABLE_SIZE = 256;
    localparam int ENTRY_AW   = TABLE_W + OCTET_BITS;
    localparam int NFREE_W    = $clog2(TABLES + 1);
    localparam logic [31:0] OCTET_MASK = 32'h0000_00ff;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    localparam logic [2:0] REG_COUNT_BYTES = 3'd0;
    localparam logic [2:0] REG_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_TPS         = 3'd2;
    localparam logic [2:0] REG_PORT_DST    = 3'd3;
    localparam logic [2:0] REG_CHANGE0     = 3'd4;
    localparam logic [2:0] REG_CHANGE1     = 3'd5;
    localparam logic [2:0] REG_CHANGE2     = 3'd6;
    localparam logic [2:0] REG_CHANGE3     = 3'd7;

    typedef struct packed {
        logic [31:0]        count;
        logic [31:0]        stamp;
        logic               split;
        logic [TABLE_W-1:0] child;
    } entry_t;

    function automatic logic [7:0] octet_sel(input logic [31:0] addr, input logic [1:0] lvl);
        logic [31:0] sh;
        sh = (addr >> (5'd24 - {lvl, 3'b000})) & OCTET_MASK;
        return sh[7:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/apt_if.sv =====
`default_nettype none
interface apt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [1:0]         port;
    logic [31:0]        src_addr;
    logic [31:0]        dst_addr;
    logic [15:0]        ip_len;
    logic signed [31:0] reset_value;
    modport source (output valid, command, port, src_addr, dst_addr, ip_len, reset_value,
                    input ready);
    modport sink (input valid, command, port, src_addr, dst_addr, ip_len, reset_value,
                  output ready);
endinterface

interface apt_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] counter_value;
    logic [1:0]         level;
    logic               split_made;
    logic               split_refused;
    modport source (output valid, counter_value, level, split_made, split_refused,
                    input ready);
    modport sink (input valid, counter_value, level, split_made, split_refused,
                  output ready);
endinterface
`default_nettype wire

// ===== design/adaptive_prefix_traffic_counter.sv =====
// Packets walk a trie of 256-entry tables held in one synchronous memory,
// one read per level over one to four levels; a split sweeps a new table
// clear before the result is given. A reset request sweeps the root table.
// Requests are taken only when idle, once the last result is in the output
// register. After rst_n the root table is swept before the first request
// is taken. The user must make configuration writes only while no request
// is in flight; the block itself does not enforce this.
`default_nettype none
`include "adaptive_prefix_traffic_counter_macros.svh"
module adaptive_prefix_traffic_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    apt_req_if.sink          req,
    apt_res_if.source        res
);
    import apt_pkg::*;

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;

    logic               count_bytes_reg;
    logic signed [31:0] threshold_reg;
    logic [31:0]        tps_reg;
    logic [3:0]         port_dst_reg;
    logic signed [16:0] change_reg [PORTS];

    logic [31:0]        time_reg;
    logic [NFREE_W-1:0] next_free_reg;
    logic [31:0]        addr_reg;
    logic [31:0]        weight_reg;
    logic [TABLE_W-1:0] table_reg;
    logic [1:0]         lvl_reg;
    logic [TABLE_W-1:0] clr_table_reg;
    logic [31:0]        clr_value_reg;
    logic [7:0]         clr_cnt_reg;

    logic [31:0] res_count_reg;
    logic [1:0]  res_level_reg;
    logic        res_made_reg;
    logic        res_refused_reg;

    logic        out_valid_reg;
    logic [31:0] out_count_reg;
    logic [1:0]  out_level_reg;
    logic        out_made_reg;
    logic        out_refused_reg;

    entry_t mem [TABLES*TABLE_SIZE];
    entry_t rd_q;
    logic [ENTRY_AW-1:0] rd_addr;
    logic                mem_we;
    logic [ENTRY_AW-1:0] wr_addr;
    entry_t              wr_data;

    logic [31:0]  cnt;
    logic         reach;
    logic         in_window;
    logic         not_last;
    logic         descend;
    logic         pool_ok;
    logic         do_split;
    logic signed [33:0] product;
    logic [31:0]  weight;
    logic         port_ok;
    logic [2:0]   port_x;

    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.counter_value = out_count_reg;
    assign res.level = out_level_reg;
    assign res.split_made = out_made_reg;
    assign res.split_refused = out_refused_reg;

    assign port_x  = {1'b0, req.port};
    assign port_ok = (port_x < 3'(PORTS));
    assign product = $signed(change_reg[req.port]) * $signed({1'b0, req.ip_len});
    assign weight  = count_bytes_reg ? product[31:0]
                                     : {{15{change_reg[req.port][16]}}, change_reg[req.port]};

    assign rd_addr   = {table_reg, octet_sel(addr_reg, lvl_reg)};
    assign not_last  = ({1'b0, lvl_reg} + 3'd1) < 3'(LEVELS);
    assign descend   = rd_q.split && not_last;
    assign cnt       = rd_q.count + weight_reg;
    assign reach     = $signed(cnt) >= threshold_reg;
    assign in_window = (time_reg - rd_q.stamp) < tps_reg;
    assign pool_ok   = next_free_reg < NFREE_W'(TABLES);
    assign do_split  = reach && in_window && not_last && pool_ok;

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = {clr_table_reg, clr_cnt_reg};
        wr_data = '{count: clr_value_reg, stamp: time_reg, split: 1'b0, child: '0};
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_EVAL:
            begin
                if (!descend)
                begin
                    mem_we        = 1'b1;
                    wr_addr       = rd_addr;
                    wr_data       = rd_q;
                    wr_data.count = cnt;
                    if (reach && !in_window)
                        wr_data.stamp = time_reg;
                    if (do_split)
                    begin
                        wr_data.split = 1'b1;
                        wr_data.child = next_free_reg[TABLE_W-1:0];
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_bytes_reg <= 1'b0;
            threshold_reg   <= 32'sd1000;
            tps_reg         <= 32'd100;
            port_dst_reg    <= 4'hf;
            for (int i = 0; i < PORTS; i++)
                change_reg[i] <= 17'sd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNT_BYTES: count_bytes_reg <= cfg_data[0];
                REG_THRESHOLD:   threshold_reg   <= cfg_data;
                REG_TPS:         tps_reg         <= cfg_data;
                REG_PORT_DST:    port_dst_reg    <= cfg_data[3:0];
                REG_CHANGE0:     change_reg[0]   <= cfg_data[16:0];
                REG_CHANGE1:     change_reg[1]   <= cfg_data[16:0];
                REG_CHANGE2:     change_reg[2]   <= cfg_data[16:0];
                REG_CHANGE3:     change_reg[3]   <= cfg_data[16:0];
                default:         count_bytes_reg <= count_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            time_reg      <= '0;
            next_free_reg <= NFREE_W'(1);
            clr_table_reg <= '0;
            clr_value_reg <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 8'd1;
                    if (clr_cnt_reg == 8'hff)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        addr_reg        <= port_dst_reg[req.port] ? req.dst_addr
                                                                  : req.src_addr;
                        weight_reg      <= weight;
                        table_reg       <= '0;
                        lvl_reg         <= '0;
                        res_count_reg   <= '0;
                        res_level_reg   <= '0;
                        res_made_reg    <= 1'b0;
                        res_refused_reg <= 1'b0;
                        clr_cnt_reg     <= '0;
                        case (req.command)
                            CMD_PACKET:
                            begin
                                if (port_ok)
                                    state_reg <= S_READ;
                                else
                                    state_reg <= S_DONE;
                            end
                            CMD_TICK:
                            begin
                                time_reg  <= time_reg + 32'd1;
                                state_reg <= S_DONE;
                            end
                            CMD_RESET:
                            begin
                                clr_table_reg <= '0;
                                clr_value_reg <= req.reset_value;
                                next_free_reg <= NFREE_W'(1);
                                state_reg     <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (descend)
                    begin
                        table_reg <= rd_q.child;
                        lvl_reg   <= lvl_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        res_count_reg   <= cnt;
                        res_level_reg   <= lvl_reg;
                        res_made_reg    <= do_split;
                        res_refused_reg <= reach && in_window && not_last && !pool_ok;
                        if (do_split)
                        begin
                            clr_table_reg <= next_free_reg[TABLE_W-1:0];
                            clr_value_reg <= '0;
                            next_free_reg <= next_free_reg + NFREE_W'(1);
                            state_reg     <= S_CLEAR;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 8'd1;
                    if (clr_cnt_reg == 8'hff)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_count_reg   <= res_count_reg;
                        out_level_reg   <= res_level_reg;
                        out_made_reg    <= res_made_reg;
                        out_refused_reg <= res_refused_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `APT_ASSERT_ALWAYS(a_pool_bound, clk, rst_n, next_free_reg <= NFREE_W'(TABLES))
    `APT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req.valid && req.ready, state_reg != S_IDLE)
    `APT_ASSERT_NEXT(a_split_sweeps, clk, rst_n, state_reg == S_EVAL && do_split && !descend, state_reg == S_CLEAR && clr_cnt_reg == 8'd0)
endmodule
`default_nettype wire

// ===== tb/sv/tb_adaptive_prefix_traffic_counter.sv =====
`default_nettype none
module tb_adaptive_prefix_traffic_counter;
    import apt_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int ENTRIES = TABLES * TABLE_SIZE;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  command;
        logic [1:0]  port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ip_len;
        logic [31:0] reset_value;
    } pkt_req_t;

    typedef struct {
        logic [31:0] counter_value;
        logic [1:0]  level;
        logic        split_made;
        logic        split_refused;
    } count_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    apt_req_if req ();
    apt_res_if res ();

    adaptive_prefix_traffic_counter dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req.sink),
        .res(res.source)
    );

    // shadow trie state and registers
    logic [31:0] cnt_mem [ENTRIES];
    logic [31:0] stamp_mem [ENTRIES];
    logic        split_mem [ENTRIES];
    logic [5:0]  child_mem [ENTRIES];
    int unsigned next_free;
    logic [31:0] now_ticks;
    logic        sh_count_bytes;
    logic [31:0] sh_threshold;
    logic [31:0] sh_tps;
    logic [3:0]  sh_port_dst;
    logic [16:0] sh_change [4];

    pkt_req_t   pending_reqs [$];
    count_res_t expected_counts [$];
    int errors;
    longint cycles;
    bit no_idle;
    int req_gap;
    int res_stall;
    logic [31:0] addr_pool [6];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_table(int tbl, logic [31:0] value);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            cnt_mem[tbl * TABLE_SIZE + i] = value;
            stamp_mem[tbl * TABLE_SIZE + i] = now_ticks;
            split_mem[tbl * TABLE_SIZE + i] = 1'b0;
        end
    endfunction

    function automatic count_res_t count_packet(pkt_req_t r);
        count_res_t o;
        logic [31:0] addr;
        longint w;
        logic [31:0] weight;
        logic [31:0] sum;
        int tbl;
        int lv;
        int idx;
        o = '{default: '0};
        case (r.command)
            CMD_TICK: now_ticks = now_ticks + 32'd1;
            CMD_RESET:
            begin
                clear_table(0, r.reset_value);
                next_free = 1;
            end
            CMD_PACKET:
            begin
                if (r.port < PORTS)
                begin
                    addr = sh_port_dst[r.port] ? r.dst_addr : r.src_addr;
                    w = longint'($signed(sh_change[r.port]));
                    if (sh_count_bytes)
                        w = w * longint'(r.ip_len);
                    weight = w[31:0];
                    tbl = 0;
                    lv = 0;
                    idx = (addr >> 24) & 32'hff;
                    while (split_mem[idx] && lv + 1 < LEVELS)
                    begin
                        tbl = child_mem[idx];
                        lv++;
                        idx = tbl * TABLE_SIZE + ((addr >> (24 - 8 * lv)) & 32'hff);
                    end
                    sum = cnt_mem[idx] + weight;
                    cnt_mem[idx] = sum;
                    if ($signed(sum) >= $signed(sh_threshold))
                    begin
                        if (now_ticks - stamp_mem[idx] < sh_tps)
                        begin
                            if (lv + 1 < LEVELS)
                            begin
                                if (next_free < TABLES)
                                begin
                                    clear_table(next_free, 32'd0);
                                    child_mem[idx] = next_free[5:0];
                                    split_mem[idx] = 1'b1;
                                    next_free++;
                                    o.split_made = 1'b1;
                                end
                                else
                                    o.split_refused = 1'b1;
                            end
                        end
                        else
                            stamp_mem[idx] = now_ticks;
                    end
                    o.counter_value = sum;
                    o.level = lv[1:0];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req_gap = 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
            begin
                count_res_t e;
                e = count_packet('{req.command, req.port, req.src_addr,
                    req.dst_addr, req.ip_len, req.reset_value});
                expected_counts = {expected_counts, e};
            end
            if (req_gap > 0)
            begin
                req_gap--;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                pkt_req_t p;
                p = pending_reqs.pop_front();
                req.command <= p.command;
                req.port <= p.port;
                req.src_addr <= p.src_addr;
                req.dst_addr <= p.dst_addr;
                req.ip_len <= p.ip_len;
                req.reset_value <= p.reset_value;
                req.valid <= 1'b1;
                req_gap = pick_gap();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_stall = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected result counter_value=%0d", res.counter_value);
                    errors++;
                end
                else
                begin
                    count_res_t e;
                    e = expected_counts.pop_front();
                    if (res.counter_value !== e.counter_value)
                    begin
                        $error("counter_value expected %0d actual %0d",
                               $signed(e.counter_value), res.counter_value);
                        errors++;
                    end
                    if (res.level !== e.level)
                    begin
                        $error("level expected %0d actual %0d", e.level, res.level);
                        errors++;
                    end
                    if (res.split_made !== e.split_made)
                    begin
                        $error("split_made expected %0b actual %0b", e.split_made,
                               res.split_made);
                        errors++;
                    end
                    if (res.split_refused !== e.split_refused)
                    begin
                        $error("split_refused expected %0b actual %0b", e.split_refused,
                               res.split_refused);
                        errors++;
                    end
                end
            end
            if (res_stall > 0)
            begin
                res_stall--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                res_stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            REG_COUNT_BYTES: sh_count_bytes = value[0];
            REG_THRESHOLD:   sh_threshold = value;
            REG_TPS:         sh_tps = value;
            REG_PORT_DST:    sh_port_dst = value[3:0];
            REG_CHANGE0:     sh_change[0] = value[16:0];
            REG_CHANGE1:     sh_change[1] = value[16:0];
            REG_CHANGE2:     sh_change[2] = value[16:0];
            default:         sh_change[3] = value[16:0];
        endcase
    endtask

    task automatic configure(logic cb, logic [31:0] thr, logic [31:0] tps, logic [3:0] pd,
                             logic [16:0] c0, logic [16:0] c1, logic [16:0] c2,
                             logic [16:0] c3);
        write_reg(REG_COUNT_BYTES, {31'd0, cb});
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_TPS, tps);
        write_reg(REG_PORT_DST, {28'd0, pd});
        write_reg(REG_CHANGE0, {15'd0, c0});
        write_reg(REG_CHANGE1, {15'd0, c1});
        write_reg(REG_CHANGE2, {15'd0, c2});
        write_reg(REG_CHANGE3, {15'd0, c3});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_req(logic [1:0] cmd, logic [1:0] port, logic [31:0] src,
                             logic [31:0] dst, logic [15:0] len, logic [31:0] rv);
        pkt_req_t p;
        p = '{cmd, port, src, dst, len, rv};
        pending_reqs = {pending_reqs, p};
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return addr_pool[$urandom_range(0, 5)];
        if (r < 85)
            return {addr_pool[$urandom_range(0, 5)][31:8], 8'($urandom)};
        return $urandom;
    endfunction

    task automatic queue_random(int n);
        int r;
        logic [1:0] cmd;
        logic [31:0] rv;
        for (int i = 0; i < 6; i++)
            addr_pool[i] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 199);
            if (r < 2)
                cmd = CMD_RESET;
            else if (r < 6)
                cmd = CMD_UNKNOWN;
            else if (r < 30)
                cmd = CMD_TICK;
            else
                cmd = CMD_PACKET;
            r = $urandom_range(0, 3);
            rv = r == 0 ? 32'h7fff_ffff : r == 1 ? 32'h8000_0000 : $urandom_range(0, 50);
            if ($urandom_range(0, 9) == 0)
                rv = $urandom;
            queue_req(cmd, 2'($urandom), pick_addr(), pick_addr(), 16'($urandom), rv);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || req.valid || expected_counts.size() > 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [16:0] pick_change();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 17'h0ffff;
        if (r == 1)
            return 17'h10000;
        if (r < 4)
            return 17'($urandom);
        return 17'($urandom_range(0, 4)) - 17'd1;
    endfunction

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_COUNT_BYTES;
        cfg_data = '0;
        req.valid = 1'b0;
        req.command = CMD_PACKET;
        req.port = '0;
        req.src_addr = '0;
        req.dst_addr = '0;
        req.ip_len = '0;
        req.reset_value = '0;
        res.ready = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cnt_mem[i] = '0;
            stamp_mem[i] = '0;
            split_mem[i] = 1'b0;
            child_mem[i] = '0;
        end
        next_free = 1;
        now_ticks = '0;
        sh_count_bytes = 1'b0;
        sh_threshold = 32'd1000;
        sh_tps = 32'd100;
        sh_port_dst = 4'hf;
        for (int i = 0; i < 4; i++)
            sh_change[i] = 17'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        configure(1'b0, 32'd2, 32'hffff_ffff, 4'b0101, 17'd1, 17'd1, 17'd1, 17'd1);
        @(negedge clk);
        queue_req(CMD_TICK, 2'd0, '0, '0, '0, '0);
        queue_req(CMD_UNKNOWN, 2'd3, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        for (int i = 0; i < 4; i++)
            queue_req(CMD_PACKET, 2'(i), 32'h0a00_0001, 32'hc0a8_0101, 16'd0, '0);
        for (int i = 0; i < 4; i++)
            queue_req(CMD_PACKET, 2'd1, 32'h0a01_0203, 32'h0, 16'hffff, '0);
        queue_req(CMD_PACKET, 2'd0, 32'h0, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        queue_req(CMD_PACKET, 2'd0, 32'h0, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        queue_req(CMD_RESET, 2'd0, '0, '0, '0, 32'h7fff_ffff);
        queue_req(CMD_PACKET, 2'd2, 32'h0, 32'h0, 16'd0, '0);
        queue_req(CMD_RESET, 2'd0, '0, '0, '0, 32'h8000_0000);
        queue_req(CMD_PACKET, 2'd3, 32'h0, 32'h0, 16'd0, '0);
        drain();
        configure(1'b1, 32'h7fff_ffff, 32'd1, 4'b1010, 17'h0ffff, 17'h10000, 17'h1ffff,
                  17'd2);
        @(negedge clk);
        queue_req(CMD_PACKET, 2'd0, 32'h1, 32'h2, 16'hffff, '0);
        queue_req(CMD_PACKET, 2'd1, 32'h1, 32'h2, 16'hffff, '0);
        queue_req(CMD_PACKET, 2'd2, 32'h1, 32'h2, 16'd1, '0);
        queue_req(CMD_PACKET, 2'd3, 32'h1, 32'h2, 16'd0, '0);
        queue_random(180);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph % 3 == 1);
            case (ph)
                0: configure(1'b0, 32'h8000_0000, 32'hffff_ffff, 4'h0, 17'd1, 17'd1, 17'd1,
                             17'd1);
                1: configure(1'b0, 32'd3, 32'd1, 4'hf, 17'd1, 17'd2, 17'd1, 17'd3);
                2: configure(1'b1, 32'd40000, 32'd0, 4'h5, 17'd1, 17'd1, 17'h1ffff, 17'd2);
                default: configure(1'($urandom), 32'($urandom_range(1, 40)),
                                   32'($urandom_range(1, 12)), 4'($urandom), pick_change(),
                                   pick_change(), pick_change(), pick_change());
            endcase
            @(negedge clk);
            queue_random(180);
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
